### design/vwd_pkg.sv
// ----------------------------------------------------------------------------
// vwd_pkg: shared types and constants for the vertex weld block
// Component, index and tolerance widths, and the vertex record type.
// ----------------------------------------------------------------------------
package vwd_pkg;

    localparam int unsigned TableDepth = 1024;
    localparam int unsigned CompWidth  = 24;
    localparam int unsigned TolWidth   = 23;
    localparam int unsigned IdxWidth   = $clog2(TableDepth);
    localparam int unsigned CntWidth   = $clog2(TableDepth + 1);
    localparam int unsigned NumComp    = 10;
    localparam int unsigned NumPos     = 4;

    localparam logic [0:0] RegPosTol = 1'b0;
    localparam logic [0:0] RegAttTol = 1'b1;

    typedef logic signed [CompWidth-1:0] t_comp;
    typedef t_comp t_vertex [NumComp];

endpackage

### design/vwd_cell.sv
// ----------------------------------------------------------------------------
// vwd_cell: one compare cell of the search chain
// Checks one component of a stored entry against the item and passes the
// running match flag to the next cell.
// ----------------------------------------------------------------------------
module vwd_cell (
    input  logic                          i_clk,
    input  vwd_pkg::t_comp                i_stored,
    input  vwd_pkg::t_comp                i_probe,
    input  logic [vwd_pkg::TolWidth-1:0]  i_tol,
    input  logic                          i_match,
    output logic                          o_match
);

    logic signed [vwd_pkg::CompWidth:0] w_diff;
    logic        [vwd_pkg::CompWidth:0] w_abs;
    logic                               r_match;

    // The difference is one bit wider than a component so it never wraps.
    assign w_diff = {i_stored[vwd_pkg::CompWidth-1], i_stored}
                  - {i_probe[vwd_pkg::CompWidth-1], i_probe};
    assign w_abs  = w_diff[vwd_pkg::CompWidth] ? (~w_diff + 1'b1) : w_diff;

    always_ff @(posedge i_clk) begin
        r_match <= i_match
                && (w_abs < {{(vwd_pkg::CompWidth + 1 - vwd_pkg::TolWidth){1'b0}}, i_tol});
    end

    assign o_match = r_match;

endmodule

### design/vertex_weld_dedup.sv
// ----------------------------------------------------------------------------
// vertex_weld_dedup: vertex welding with tolerance
// Finds the first stored vertex within tolerance of each incoming item, or
// appends the item as a new entry, or flags the table as full.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  in       | i_in_valid/o_in_stall| i_pos_*, i_nrm_*, i_col_*
//  out      | o_out_valid/i_out_stall | o_vertex_index, o_was_added, o_table_full
//  cfg      | APB write/read       | position and attribute tolerance
//
// An item is accepted only once the search for the previous one has handed
// over its result: the search reads one table entry a cycle from one read
// port per component memory, and the entry then walks a chain of ten compare
// cells, one component per cell, each registering its running match flag.
// The first matching address wins and stops further reads. The result is
// loaded into the output register once the chain has drained.
// Reset clears the count and control state; the tables need no clearing
// because only entries below the count are ever read.
// A result that waits on i_out_stall holds back only the end of the next
// search, which cannot hand over its result until the output register is free.
// ----------------------------------------------------------------------------
module vertex_weld_dedup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  vwd_pkg::t_comp                i_pos_x,
    input  vwd_pkg::t_comp                i_pos_y,
    input  vwd_pkg::t_comp                i_pos_z,
    input  vwd_pkg::t_comp                i_pos_w,
    input  vwd_pkg::t_comp                i_nrm_x,
    input  vwd_pkg::t_comp                i_nrm_y,
    input  vwd_pkg::t_comp                i_nrm_z,
    input  vwd_pkg::t_comp                i_col_r,
    input  vwd_pkg::t_comp                i_col_g,
    input  vwd_pkg::t_comp                i_col_b,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vwd_pkg::IdxWidth-1:0]  o_vertex_index,
    output logic                          o_was_added,
    output logic                          o_table_full,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned Lat = vwd_pkg::NumComp + 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} t_state;

    t_state                            r_state;
    logic [vwd_pkg::TolWidth-1:0]      r_pos_tol, r_att_tol;
    logic [vwd_pkg::CntWidth-1:0]      r_count;
    logic [vwd_pkg::CntWidth-1:0]      r_rd_addr;   // next address to read
    logic [Lat-1:0]                    r_vld;       // valid of each stage
    logic [vwd_pkg::IdxWidth-1:0]      r_idx [Lat];
    logic                              r_found;
    logic [vwd_pkg::IdxWidth-1:0]      r_found_idx;
    vwd_pkg::t_comp                    r_probe [vwd_pkg::NumComp];
    vwd_pkg::t_comp                    mem [vwd_pkg::NumComp][vwd_pkg::TableDepth];
    vwd_pkg::t_comp                    r_rd [vwd_pkg::NumComp];
    vwd_pkg::t_comp                    r_dly [vwd_pkg::NumComp][vwd_pkg::NumComp];
    logic [vwd_pkg::NumComp:0]         w_chain;
    logic                              r_out_valid;
    logic [vwd_pkg::IdxWidth-1:0]      r_out_idx;
    logic                              r_out_add, r_out_full;
    logic                              w_wr;
    logic                              w_rd_en;
    logic                              w_out_free;
    logic                              w_done;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_tol <= vwd_pkg::TolWidth'(66);
            r_att_tol <= vwd_pkg::TolWidth'(655);
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                vwd_pkg::RegPosTol: r_pos_tol <= pwdata[vwd_pkg::TolWidth-1:0];
                vwd_pkg::RegAttTol: r_att_tol <= pwdata[vwd_pkg::TolWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            vwd_pkg::RegPosTol: prdata[vwd_pkg::TolWidth-1:0] = r_pos_tol;
            vwd_pkg::RegAttTol: prdata[vwd_pkg::TolWidth-1:0] = r_att_tol;
            default: ;
        endcase
    end

    assign w_rd_en = (r_state == S_SCAN) && (r_rd_addr < r_count) && !r_found;

    // A search is done once the chain has drained; it hands over its result
    // when the output register is empty or its result leaves at this edge.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_done     = (r_state == S_DRAIN) && (r_vld == '0) && w_out_free;

    // One registered read per table per cycle; components for later cells wait
    // in a delay line so each reaches its cell together with the entry's match flag.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < vwd_pkg::NumComp; c++) begin
            r_rd[c] <= mem[c][r_rd_addr[vwd_pkg::IdxWidth-1:0]];
            r_dly[c][0] <= r_rd[c];
            for (int k = 1; k < vwd_pkg::NumComp; k++) r_dly[c][k] <= r_dly[c][k-1];
        end
        if (w_done && !r_found
            && r_count < vwd_pkg::CntWidth'(vwd_pkg::TableDepth)) begin
            for (int c = 0; c < vwd_pkg::NumComp; c++)
                mem[c][r_count[vwd_pkg::IdxWidth-1:0]] <= r_probe[c];
        end
    end

    assign w_chain[0] = 1'b1;
    for (genvar g = 0; g < vwd_pkg::NumComp; g++) begin : g_cell
        vwd_cell u_cell (
            .i_clk    (i_clk),
            .i_stored (g == 0 ? r_rd[g] : r_dly[g][(g == 0) ? 0 : g-1]),
            .i_probe  (r_probe[g]),
            .i_tol    (g < vwd_pkg::NumPos ? r_pos_tol : r_att_tol),
            .i_match  (w_chain[g]),
            .o_match  (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_probe[0] <= i_pos_x; r_probe[1] <= i_pos_y;
            r_probe[2] <= i_pos_z; r_probe[3] <= i_pos_w;
            r_probe[4] <= i_nrm_x; r_probe[5] <= i_nrm_y;
            r_probe[6] <= i_nrm_z; r_probe[7] <= i_col_r;
            r_probe[8] <= i_col_g; r_probe[9] <= i_col_b;
        end
        r_idx[0] <= r_rd_addr[vwd_pkg::IdxWidth-1:0];
        for (int k = 1; k < Lat; k++) r_idx[k] <= r_idx[k-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_addr   <= '0;
            r_vld       <= '0;
            r_found     <= 1'b0;
            r_found_idx <= '0;
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
            r_out_add   <= 1'b0;
            r_out_full  <= 1'b0;
        end else begin
            r_vld <= {r_vld[Lat-2:0], w_rd_en};
            // The first match in address order wins; later ones are ignored.
            if (r_vld[Lat-1] && w_chain[vwd_pkg::NumComp] && !r_found) begin
                r_found     <= 1'b1;
                r_found_idx <= r_idx[Lat-1];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state   <= S_SCAN;
                        r_rd_addr <= '0;
                        r_found   <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (w_rd_en) r_rd_addr <= r_rd_addr + 1'b1;
                    else         r_state   <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (w_done) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // The output register loads a finished search's result, or empties
            // when its result is taken and no new one is ready.
            if (w_done) begin
                r_out_valid <= 1'b1;
                if (r_found) begin
                    r_out_idx  <= r_found_idx;
                    r_out_add  <= 1'b0;
                    r_out_full <= 1'b0;
                end else if (r_count
                             < vwd_pkg::CntWidth'(vwd_pkg::TableDepth)) begin
                    r_out_idx  <= r_count[vwd_pkg::IdxWidth-1:0];
                    r_out_add  <= 1'b1;
                    r_out_full <= 1'b0;
                    r_count    <= r_count + 1'b1;
                end else begin
                    r_out_idx  <= '0;
                    r_out_add  <= 1'b0;
                    r_out_full <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_vertex_index = r_out_idx;
    assign o_was_added    = r_out_add;
    assign o_table_full   = r_out_full;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= vwd_pkg::CntWidth'(vwd_pkg::TableDepth))
        else $error("count beyond depth");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_was_added && o_table_full))
        else $error("added and full together");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_vertex_index)
            && $stable(o_was_added) && $stable(o_table_full))
        else $error("stalled result changed");
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_was_added |-> r_count == {1'b0, o_vertex_index} + 1'b1)
        else $error("added index not last entry");
`endif

endmodule

### tb/vertex_weld_dedup_checker.sv
// ----------------------------------------------------------------------------
// vertex_weld_dedup_checker: result predictor and scoreboard for vertex welding
// Watches the input, output and register channels of the weld block. It keeps
// its own copy of the vertex table and tolerances, predicts the index and flags
// of each accepted item, and compares them in order with the block's results.
// ----------------------------------------------------------------------------
module vertex_weld_dedup_checker (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    input  logic                                         i_in_stall,
    input  logic [vwd_pkg::NumComp*vwd_pkg::CompWidth-1:0] i_vertex_bits,
    input  logic                                         i_out_valid,
    input  logic                                         i_out_stall,
    input  logic [vwd_pkg::IdxWidth-1:0]                 i_vertex_index,
    input  logic                                         i_was_added,
    input  logic                                         i_table_full,
    input  logic                                         i_psel,
    input  logic                                         i_penable,
    input  logic                                         i_pwrite,
    input  logic                                         i_pready,
    input  logic [2:0]                                   i_paddr,
    input  logic [31:0]                                  i_pwdata,
    output int                                           o_errors,
    output int                                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [vwd_pkg::IdxWidth-1:0] index;
        logic                         added;
        logic                         full;
    } t_weld;

    t_weld                        expected_welds[$];
    vwd_pkg::t_comp               weld_table [vwd_pkg::NumComp][vwd_pkg::TableDepth];
    int unsigned                  stored_cnt = 0;
    logic [vwd_pkg::TolWidth-1:0] pos_tol = vwd_pkg::TolWidth'(66);
    logic [vwd_pkg::TolWidth-1:0] att_tol = vwd_pkg::TolWidth'(655);

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // First stored entry within tolerance on all ten components wins;
    // otherwise the vertex is appended if there is room.
    function automatic t_weld weld_lookup(
        input logic [vwd_pkg::NumComp*vwd_pkg::CompWidth-1:0] bits);
        t_weld           r;
        vwd_pkg::t_comp  v [vwd_pkg::NumComp];
        longint          d;
        bit              hit;
        r = '0;
        for (int c = 0; c < vwd_pkg::NumComp; c++)
            v[c] = $signed(bits[c*vwd_pkg::CompWidth +: vwd_pkg::CompWidth]);
        for (int unsigned i = 0; i < stored_cnt; i++) begin
            hit = 1'b1;
            for (int c = 0; c < vwd_pkg::NumComp; c++) begin
                d = longint'(weld_table[c][i]) - longint'(v[c]);
                if (d < 0) d = -d;
                if (d >= longint'(c < vwd_pkg::NumPos ? pos_tol : att_tol)) hit = 1'b0;
            end
            if (hit) begin
                r.index = vwd_pkg::IdxWidth'(i);
                return r;
            end
        end
        if (stored_cnt >= vwd_pkg::TableDepth) begin
            r.full = 1'b1;
            return r;
        end
        for (int c = 0; c < vwd_pkg::NumComp; c++) weld_table[c][stored_cnt] = v[c];
        r.index = vwd_pkg::IdxWidth'(stored_cnt);
        r.added = 1'b1;
        stored_cnt++;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_weld exp_w;
        t_weld act_w;
        if (i_rst_n) begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == vwd_pkg::RegPosTol) pos_tol = i_pwdata[vwd_pkg::TolWidth-1:0];
                if (i_paddr[2] == vwd_pkg::RegAttTol) att_tol = i_pwdata[vwd_pkg::TolWidth-1:0];
            end
            if (i_in_valid && !i_in_stall)
                expected_welds.insert(expected_welds.size(), weld_lookup(i_vertex_bits));
            if (i_out_valid && !i_out_stall) begin
                act_w = '{i_vertex_index, i_was_added, i_table_full};
                if (expected_welds.size() == 0) begin
                    $display("%0t: unexpected result index=%0d added=%0b full=%0b",
                             $time, act_w.index, act_w.added, act_w.full);
                    o_errors++;
                end else begin
                    exp_w = expected_welds.pop_front();
                    if (exp_w.index !== act_w.index) begin
                        $display("%0t: vertex_index expected %0d actual %0d",
                                 $time, exp_w.index, act_w.index);
                        o_errors++;
                    end
                    if (exp_w.added !== act_w.added) begin
                        $display("%0t: was_added expected %0b actual %0b",
                                 $time, exp_w.added, act_w.added);
                        o_errors++;
                    end
                    if (exp_w.full !== act_w.full) begin
                        $display("%0t: table_full expected %0b actual %0b",
                                 $time, exp_w.full, act_w.full);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_welds.size();
    end

endmodule

### tb/vertex_weld_dedup_tb.sv
// ----------------------------------------------------------------------------
// vertex_weld_dedup_tb: stimulus and verdict for the vertex weld block
// Drives directed and random vertices through several tolerance settings
// and lets the checker judge every result.
// ----------------------------------------------------------------------------
module vertex_weld_dedup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    vwd_pkg::t_comp               i_pos_x = '0, i_pos_y = '0, i_pos_z = '0, i_pos_w = '0;
    vwd_pkg::t_comp               i_nrm_x = '0, i_nrm_y = '0, i_nrm_z = '0;
    vwd_pkg::t_comp               i_col_r = '0, i_col_g = '0, i_col_b = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [vwd_pkg::IdxWidth-1:0] o_vertex_index;
    logic                         o_was_added;
    logic                         o_table_full;
    logic                         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]                   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    int errors, pending;

    // When set, neither side idles; used for the closing part of the run.
    bit quiet = 1'b0;

    // The tolerances as last written, used to aim near-duplicates at the
    // edges of the match window.
    int unsigned pos_tol_now = 66;
    int unsigned att_tol_now = 655;

    // Every vertex sent so far, the pool that near-duplicates come from.
    vwd_pkg::t_vertex sent_vertices[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vertex_weld_dedup u_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_pos_w, .i_nrm_x, .i_nrm_y, .i_nrm_z,
        .i_col_r, .i_col_g, .i_col_b,
        .o_out_valid, .i_out_stall, .o_vertex_index, .o_was_added, .o_table_full,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    vertex_weld_dedup_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall),
        .i_vertex_bits({i_col_b, i_col_g, i_col_r, i_nrm_z, i_nrm_y, i_nrm_x,
                        i_pos_w, i_pos_z, i_pos_y, i_pos_x}),
        .i_out_valid(o_out_valid), .i_out_stall, .i_vertex_index(o_vertex_index),
        .i_was_added(o_was_added), .i_table_full(o_table_full),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    // The receiver alternates stall bursts with free stretches, some of them
    // long, so stalls land on every phase of a search.
    always @(posedge i_clk) begin
        static int stall_left = 0;
        static int free_left  = 0;
        if (quiet || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 3) == 0) free_left = $urandom_range(20, 300);
            else stall_left = $urandom_range(1, 14);
            i_out_stall <= 1'b0;
        end
    end

    // Presents one item, with an occasional idle burst before it, and returns
    // at the edge where it is accepted. Valid stays high into the next call
    // unless that call idles, so it is never dropped and raised in one step.
    task automatic send_vertex(input vwd_pkg::t_vertex v);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x <= v[0]; i_pos_y <= v[1]; i_pos_z <= v[2]; i_pos_w <= v[3];
        i_nrm_x <= v[4]; i_nrm_y <= v[5]; i_nrm_z <= v[6];
        i_col_r <= v[7]; i_col_g <= v[8]; i_col_b <= v[9];
        sent_vertices.insert(sent_vertices.size(), v);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [0:0] reg_idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == vwd_pkg::RegPosTol) pos_tol_now = value & 32'h7F_FFFF;
        else att_tol_now = value & 32'h7F_FFFF;
    endtask

    task automatic set_tolerances(input int unsigned p, input int unsigned a);
        write_tolerance(vwd_pkg::RegPosTol, p);
        write_tolerance(vwd_pkg::RegAttTol, a);
    endtask

    function automatic vwd_pkg::t_vertex flat_vertex(input vwd_pkg::t_comp value);
        vwd_pkg::t_vertex v;
        foreach (v[c]) v[c] = value;
        return v;
    endfunction

    // Fresh vertex: components anywhere in range, at the positive extreme, or
    // clustered near zero, where accidental near-matches are likely.
    function automatic vwd_pkg::t_vertex fresh_vertex();
        vwd_pkg::t_vertex v;
        foreach (v[c]) begin
            case ($urandom_range(0, 5))
                0, 1, 2: v[c] = vwd_pkg::t_comp'($urandom());
                3:       v[c] = vwd_pkg::t_comp'(int'($urandom_range(0, 2000)) - 1000);
                4:       v[c] = 24'sh7F_FFFF;
                default: v[c] = vwd_pkg::t_comp'($urandom_range(0, 40));
            endcase
        end
        return v;
    endfunction

    // Near-duplicate of an earlier vertex: each component moves by up to the
    // tolerance, sometimes exactly to or just inside the window's edge.
    function automatic vwd_pkg::t_vertex near_vertex();
        vwd_pkg::t_vertex v;
        int unsigned      tol;
        int unsigned      mag;
        v = sent_vertices[$urandom_range(0, sent_vertices.size() - 1)];
        foreach (v[c]) begin
            tol = (c < vwd_pkg::NumPos) ? pos_tol_now : att_tol_now;
            case ($urandom_range(0, 19))
                0:       mag = tol;
                1:       mag = (tol > 0) ? tol - 1 : 0;
                2, 3, 4: mag = 0;
                default: mag = (tol > 1) ? $urandom_range(0, tol - 1) : 0;
            endcase
            if ($urandom_range(0, 1) != 0) v[c] = v[c] + vwd_pkg::t_comp'(mag);
            else v[c] = v[c] - vwd_pkg::t_comp'(mag);
        end
        return v;
    endfunction

    // Random tolerance: mostly modest windows, sometimes any 23-bit value.
    function automatic int unsigned pick_tolerance();
        case ($urandom_range(0, 4))
            0:       return $urandom() & 32'h7F_FFFF;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(4, 3000);
        endcase
    endfunction

    initial begin
        vwd_pkg::t_vertex v;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset tolerances: the zero vertex, both range
        // extremes (their difference needs the extra bit), single components
        // just inside and exactly on the window's edge, repeats, bit patterns.
        send_vertex(flat_vertex('0));
        send_vertex(flat_vertex(24'sh7F_FFFF));
        send_vertex(flat_vertex(-24'sh80_0000));
        v = flat_vertex('0); v[0] = vwd_pkg::t_comp'(65);   send_vertex(v);
        v = flat_vertex('0); v[0] = vwd_pkg::t_comp'(66);   send_vertex(v);
        v = flat_vertex('0); v[5] = vwd_pkg::t_comp'(-654); send_vertex(v);
        v = flat_vertex('0); v[9] = vwd_pkg::t_comp'(655);  send_vertex(v);
        send_vertex(flat_vertex(24'sh7F_FFFF));
        v = flat_vertex(-24'sh80_0000); v[3] = -24'sh7F_FFBF; send_vertex(v);
        send_vertex(flat_vertex(24'sh55_5555));
        send_vertex(flat_vertex(-24'sh55_5556));
        drain_results();

        // Zero tolerance: nothing can match, so an exact repeat is appended.
        set_tolerances(0, 0);
        send_vertex(flat_vertex('0));
        send_vertex(flat_vertex('0));
        drain_results();

        // Widest windows, with alternating bit patterns in the registers.
        set_tolerances(32'h7F_FFFF, 32'h7F_FFFF);
        send_vertex(flat_vertex(-24'sh80_0000));
        send_vertex(fresh_vertex());
        send_vertex(flat_vertex(24'sh40_0000));
        drain_results();
        set_tolerances(32'h55_5555, 32'h2A_AAAA);
        send_vertex(fresh_vertex());
        send_vertex(near_vertex());
        drain_results();

        // Random part: triangles, mostly of near-duplicates of earlier
        // vertices, over several tolerance settings. Draining between phases
        // also makes the sender wait for every outstanding result.
        for (int ph = 0; ph < 4; ph++) begin
            set_tolerances(pick_tolerance(), pick_tolerance());
            for (int t = 0; t < 46; t++) begin
                repeat (3) begin
                    if ($urandom_range(0, 9) < 6) send_vertex(near_vertex());
                    else send_vertex(fresh_vertex());
                end
            end
            drain_results();
        end

        // Closing part without idling: zero tolerance appends every vertex,
        // then the reset windows meet an exact and a near repeat.
        quiet = 1'b1;
        set_tolerances(0, 0);
        repeat (3) send_vertex(fresh_vertex());
        drain_results();
        set_tolerances(66, 655);
        send_vertex(sent_vertices[0]);
        send_vertex(near_vertex());
        send_vertex(fresh_vertex());
        send_vertex(flat_vertex(24'sh7F_FFFF));
        drain_results();

        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("vertex_weld_dedup_tb: clean");
        end else begin
            $display("vertex_weld_dedup_tb: errors");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run, in which every search
    // reads the whole table grown so far and every result meets long stalls.
    initial begin
        #60ms;
        $display("vertex_weld_dedup_tb: errors");
        $finish;
    end

endmodule

### filelist.f
design/vwd_pkg.sv
design/vwd_cell.sv
design/vertex_weld_dedup.sv
tb/vertex_weld_dedup_checker.sv
tb/vertex_weld_dedup_tb.sv
